### hdl/p1tsm_pkg.sv
// Shared types and constants for the P1 triangle stiffness block.
// No dependencies; every other file in hdl/ imports this package.
package p1tsm_pkg;

    localparam int OUT_BITS = 32;
    localparam int ENTRIES  = 6;

    localparam logic [OUT_BITS-1:0] ENTRY_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] ENTRY_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Control that travels alongside each beat through the pipeline.
    typedef struct packed {
        logic valid;
        logic degen;
    } tag_t;

endpackage

### hdl/p1tsm_front.sv
// Front end: edge vectors, products, cross product, squared normal length and
// the six signed numerators, in six register stages. Depends on p1tsm_pkg.
module p1tsm_front
    import p1tsm_pkg::*;
#(
    parameter int CW  = 32,
    parameter int SW  = 134,
    parameter int NMW = 69
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  tag_t                              in_tag,
    input  logic signed [CW-1:0]              x0,
    input  logic signed [CW-1:0]              y0,
    input  logic signed [CW-1:0]              z0,
    input  logic signed [CW-1:0]              x1,
    input  logic signed [CW-1:0]              y1,
    input  logic signed [CW-1:0]              z1,
    input  logic signed [CW-1:0]              x2,
    input  logic signed [CW-1:0]              y2,
    input  logic signed [CW-1:0]              z2,
    output tag_t                              out_tag,
    output logic [SW-1:0]                     rad,
    output logic [ENTRIES-1:0][NMW-1:0]       mag,
    output logic [ENTRIES-1:0]                neg
);

    localparam int VW = CW + 1;
    localparam int MW = 2 * VW;
    localparam int XW = MW + 1;
    localparam int AW = MW + 2;
    localparam int NW = AW + 2;

    tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;

    logic signed [VW-1:0] v1_reg [3];
    logic signed [VW-1:0] v2_reg [3];
    logic signed [MW-1:0] ma_reg [3];
    logic signed [MW-1:0] mb_reg [3];
    logic signed [MW-1:0] aa_reg [3];
    logic signed [MW-1:0] bb_reg [3];
    logic signed [MW-1:0] pp_reg [3];
    logic signed [XW-1:0] c_reg [3];
    logic signed [AW-1:0] a_reg, b_reg, p_reg;
    logic signed [AW-1:0] ad_reg, bd_reg, pd_reg;
    logic [MW-1:0]        hh_reg [3];
    logic [MW-1:0]        hl_reg [3];
    logic [MW-1:0]        ll_reg [3];
    logic [SW-1:0]        csq_reg [3];
    logic signed [NW-1:0] n_reg [ENTRIES];
    logic [SW-1:0]        s_reg;
    logic [ENTRIES-1:0][NMW-1:0] mag_reg;
    logic [ENTRIES-1:0]   neg_reg;

    logic signed [VW-1:0] v1_next [3];
    logic signed [VW-1:0] v2_next [3];
    logic [VW-1:0]        chi_next [3];
    logic [VW-1:0]        clo_next [3];
    logic [SW-1:0]        csq_next [3];
    logic signed [NW-1:0] n_next [ENTRIES];
    logic [SW-1:0]        s_next;
    logic [ENTRIES-1:0][NMW-1:0] mag_next;
    logic [ENTRIES-1:0]   neg_next;

    always_comb
    begin
        v1_next[0] = VW'(x1) - VW'(x0);
        v1_next[1] = VW'(y1) - VW'(y0);
        v1_next[2] = VW'(z1) - VW'(z0);
        v2_next[0] = VW'(x2) - VW'(x0);
        v2_next[1] = VW'(y2) - VW'(y0);
        v2_next[2] = VW'(z2) - VW'(z0);
    end

    // Each cross component is squared from its magnitude split into two halves,
    // so no multiplier is wider than one edge component.
    always_comb
    begin
        logic signed [XW-1:0] cneg;
        logic [MW-1:0]        cabs;
        for (int k = 0; k < 3; k++)
        begin
            cneg = -c_reg[k];
            cabs = c_reg[k][XW-1] ? MW'(cneg) : MW'(c_reg[k]);
            chi_next[k] = cabs[MW-1:VW];
            clo_next[k] = cabs[VW-1:0];
            csq_next[k] = (SW'(hh_reg[k]) << MW) + (SW'(hl_reg[k]) << (VW + 1))
                        + SW'(ll_reg[k]);
        end
        n_next[0] = NW'(ad_reg) + NW'(bd_reg) - (NW'(pd_reg) <<< 1);
        n_next[1] = NW'(bd_reg);
        n_next[2] = NW'(ad_reg);
        n_next[3] = NW'(pd_reg) - NW'(bd_reg);
        n_next[4] = NW'(pd_reg) - NW'(ad_reg);
        n_next[5] = -NW'(pd_reg);
    end

    always_comb
    begin
        logic signed [NW-1:0] flip;
        s_next = csq_reg[0] + csq_reg[1] + csq_reg[2];
        for (int k = 0; k < ENTRIES; k++)
        begin
            flip = -n_reg[k];
            neg_next[k] = n_reg[k][NW-1];
            mag_next[k] = neg_next[k] ? NMW'(flip) : NMW'(n_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= '{valid: in_tag.valid, degen: 1'b0};
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= '{valid: tag5_reg.valid, degen: (s_next == '0)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v1_reg[k] <= v1_next[k];
                v2_reg[k] <= v2_next[k];
                aa_reg[k] <= v1_reg[k] * v1_reg[k];
                bb_reg[k] <= v2_reg[k] * v2_reg[k];
                pp_reg[k] <= v1_reg[k] * v2_reg[k];
                c_reg[k]  <= XW'(ma_reg[k]) - XW'(mb_reg[k]);
                hh_reg[k] <= MW'(chi_next[k]) * MW'(chi_next[k]);
                hl_reg[k] <= MW'(chi_next[k]) * MW'(clo_next[k]);
                ll_reg[k] <= MW'(clo_next[k]) * MW'(clo_next[k]);
                csq_reg[k] <= csq_next[k];
            end
            ma_reg[0] <= v1_reg[1] * v2_reg[2];
            mb_reg[0] <= v1_reg[2] * v2_reg[1];
            ma_reg[1] <= v1_reg[2] * v2_reg[0];
            mb_reg[1] <= v1_reg[0] * v2_reg[2];
            ma_reg[2] <= v1_reg[0] * v2_reg[1];
            mb_reg[2] <= v1_reg[1] * v2_reg[0];
            a_reg <= AW'(aa_reg[0]) + AW'(aa_reg[1]) + AW'(aa_reg[2]);
            b_reg <= AW'(bb_reg[0]) + AW'(bb_reg[1]) + AW'(bb_reg[2]);
            p_reg <= AW'(pp_reg[0]) + AW'(pp_reg[1]) + AW'(pp_reg[2]);
            ad_reg <= a_reg;
            bd_reg <= b_reg;
            pd_reg <= p_reg;
            for (int k = 0; k < ENTRIES; k++)
            begin
                n_reg[k] <= n_next[k];
            end
            s_reg   <= s_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign out_tag = tag6_reg;
    assign rad     = s_reg;
    assign mag     = mag_reg;
    assign neg     = neg_reg;

endmodule

### hdl/p1tsm_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// Carries a side payload alongside. Depends on p1tsm_pkg.
module p1tsm_sqrt
    import p1tsm_pkg::*;
#(
    parameter int SW   = 134,
    parameter int DW   = 67,
    parameter int PAYW = 420
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tag_t            in_tag,
    input  logic [SW-1:0]   rad,
    input  logic [PAYW-1:0] in_pay,
    output tag_t            out_tag,
    output logic [DW-1:0]   root,
    output logic [PAYW-1:0] out_pay
);

    tag_t            tag_reg [DW];
    logic [DW-1:0]   r_reg   [DW];
    logic [SW-1:0]   rem_reg [DW];
    logic [PAYW-1:0] pay_reg [DW];

    for (genvar g = 0; g < DW; g++)
    begin : g_stage
        localparam int B = DW - 1 - g;
        tag_t            tag_in;
        logic [DW-1:0]   r_in;
        logic [SW-1:0]   rem_in;
        logic [PAYW-1:0] pay_in;
        logic [SW:0]     trial;
        logic            take;
        logic [DW-1:0]   r_next;
        logic [SW-1:0]   rem_next;
        logic [SW:0]     diff;

        if (g == 0)
        begin : g_first
            assign tag_in = in_tag;
            assign r_in   = '0;
            assign rem_in = rad;
            assign pay_in = in_pay;
        end
        else
        begin : g_rest
            assign tag_in = tag_reg[g-1];
            assign r_in   = r_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign pay_in = pay_reg[g-1];
        end

        // Adding bit B to the root raises its square by 2*r*2^B + 2^(2B).
        assign trial = ({{(SW+1-DW){1'b0}}, r_in} << (B + 1))
                     | ((SW+1)'(1) << (2 * B));
        assign take  = {1'b0, rem_in} >= trial;
        assign diff  = {1'b0, rem_in} - trial;

        always_comb
        begin
            r_next   = take ? (r_in | (DW'(1) << B)) : r_in;
            rem_next = take ? diff[SW-1:0] : rem_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[g] <= '0;
            end
            else if (en)
            begin
                tag_reg[g] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[g]   <= r_next;
                rem_reg[g] <= rem_next;
                pay_reg[g] <= pay_in;
            end
        end
    end

    assign out_tag = tag_reg[DW-1];
    assign root    = r_reg[DW-1];
    assign out_pay = pay_reg[DW-1];

endmodule

### hdl/p1tsm_div.sv
// Pipelined restoring divider for one stiffness entry: saturation check,
// one quotient bit per stage, then sign and clamp. Depends on p1tsm_pkg.
module p1tsm_div
    import p1tsm_pkg::*;
#(
    parameter int NUMW = 86,
    parameter int DENW = 68
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  tag_t                in_tag,
    input  logic [NUMW-1:0]     num,
    input  logic [DENW-1:0]     den,
    input  logic                neg,
    output tag_t                out_tag,
    output logic [OUT_BITS-1:0] entry
);

    localparam int QB = OUT_BITS - 1;
    localparam int WW = NUMW + OUT_BITS;

    tag_t              tag_reg [QB+1];
    logic [NUMW-1:0]   rem_reg [QB+1];
    logic [DENW-1:0]   den_reg [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic              sat_reg [QB+1];
    logic              neg_reg [QB+1];
    tag_t              otag_reg;
    logic [OUT_BITS-1:0] entry_reg;
    logic [OUT_BITS-1:0] entry_next;

    // Quotients of 2^(OUT_BITS-1) or more clamp whatever the sign.
    logic sat_next;
    assign sat_next = WW'(num) >= (WW'(den) << QB);

    for (genvar g = 1; g <= QB; g++)
    begin : g_bit
        localparam int B = QB - g;
        logic [WW-1:0]   shd;
        logic            take;
        logic [NUMW-1:0] rem_next;
        logic [QB-1:0]   q_next;

        assign shd  = WW'(den_reg[g-1]) << B;
        assign take = WW'(rem_reg[g-1]) >= shd;

        always_comb
        begin
            rem_next = take ? (rem_reg[g-1] - NUMW'(shd)) : rem_reg[g-1];
            q_next   = take ? (q_reg[g-1] | (QB'(1) << B)) : q_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[g] <= '0;
            end
            else if (en)
            begin
                tag_reg[g] <= tag_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_reg[g-1];
                q_reg[g]   <= q_next;
                sat_reg[g] <= sat_reg[g-1];
                neg_reg[g] <= neg_reg[g-1];
            end
        end
    end

    always_comb
    begin
        if (tag_reg[QB].degen)
        begin
            entry_next = '0;
        end
        else if (sat_reg[QB])
        begin
            entry_next = neg_reg[QB] ? ENTRY_MIN : ENTRY_MAX;
        end
        else if (neg_reg[QB])
        begin
            entry_next = -{1'b0, q_reg[QB]};
        end
        else
        begin
            entry_next = {1'b0, q_reg[QB]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
            otag_reg   <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
            otag_reg   <= tag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_next;
            neg_reg[0] <= neg;
            entry_reg  <= entry_next;
        end
    end

    assign out_tag = otag_reg;
    assign entry   = entry_reg;

endmodule

### hdl/p1_triangle_stiffness_matrix.sv
// Top level of the P1 triangle Laplace stiffness block: input skid stage,
// front end, square root and six dividers. Depends on p1tsm_pkg and submodules.
//
// Usage: present the nine vertex coordinates (signed, FRAC_BITS fraction bits)
// with in_valid; a beat is taken on a rising edge where in_valid is high and
// in_stall is low. Each triangle gives one result beat on out_valid carrying
// k00, k11, k22, k01, k02, k12 (signed Q16.16, saturated) and degenerate,
// which is set with all entries zero when the triangle has no area.
// Throughput is one triangle per cycle while the receiver keeps out_stall low.
// The pipeline has six front-end stages, one stage per root bit in the
// square root, and 33 divider stages (saturation check, 31 quotient bits,
// sign and clamp).
// When the receiver raises out_stall with a result waiting, the whole pipeline
// freezes in place; a beat offered in that cycle lands in a one-entry skid
// register, and in_stall (a register output) stays high until it drains.
// Reset (rst_n low, asynchronous) empties the pipeline and the skid register;
// no clearing pass is needed afterwards.
module p1_triangle_stiffness_matrix
    import p1tsm_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS-1:0] z0,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] z1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic signed [COORD_BITS-1:0] z2,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] k00,
    output logic signed [OUT_BITS-1:0] k11,
    output logic signed [OUT_BITS-1:0] k22,
    output logic signed [OUT_BITS-1:0] k01,
    output logic signed [OUT_BITS-1:0] k02,
    output logic signed [OUT_BITS-1:0] k12,
    output logic                       degenerate
);

    localparam int CW   = COORD_BITS;
    localparam int MW   = 2 * (CW + 1);
    localparam int XW   = MW + 1;
    localparam int SW   = 2 * XW;
    localparam int DW   = XW;
    localparam int NMW  = MW + 3;
    localparam int PAYW = ENTRIES * NMW + ENTRIES;
    localparam int NUMW = NMW + FRAC_BITS + 1;
    localparam int DENW = DW + 1;

    logic en;
    logic accept;
    logic skid_valid_reg, skid_valid_next;
    logic signed [CW-1:0] skid_reg [9];
    logic signed [CW-1:0] in_crd [9];
    logic signed [CW-1:0] fe_crd [9];
    tag_t fe_tag;

    tag_t                        fr_tag;
    logic [SW-1:0]               fr_rad;
    logic [ENTRIES-1:0][NMW-1:0] fr_mag;
    logic [ENTRIES-1:0]          fr_neg;

    tag_t                        sq_tag;
    logic [DW-1:0]               sq_root;
    logic [PAYW-1:0]             sq_pay;
    logic [ENTRIES-1:0][NMW-1:0] sq_mag;
    logic [ENTRIES-1:0]          sq_neg;

    tag_t                        dv_tag [ENTRIES];
    logic [OUT_BITS-1:0]         dv_entry [ENTRIES];
    logic [ENTRIES-1:0]          dv_valid;

    // The pipeline moves unless a finished beat is held by the receiver.
    assign en       = !(out_valid && out_stall);
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;

    assign in_crd[0] = x0;
    assign in_crd[1] = y0;
    assign in_crd[2] = z0;
    assign in_crd[3] = x1;
    assign in_crd[4] = y1;
    assign in_crd[5] = z1;
    assign in_crd[6] = x2;
    assign in_crd[7] = y2;
    assign in_crd[8] = z2;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
        fe_tag = '{valid: (skid_valid_reg || in_valid), degen: 1'b0};
        for (int k = 0; k < 9; k++)
        begin
            fe_crd[k] = skid_valid_reg ? skid_reg[k] : in_crd[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && accept)
        begin
            for (int k = 0; k < 9; k++)
            begin
                skid_reg[k] <= in_crd[k];
            end
        end
    end

    p1tsm_front #(
        .CW  (CW),
        .SW  (SW),
        .NMW (NMW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (fe_tag),
        .x0      (fe_crd[0]),
        .y0      (fe_crd[1]),
        .z0      (fe_crd[2]),
        .x1      (fe_crd[3]),
        .y1      (fe_crd[4]),
        .z1      (fe_crd[5]),
        .x2      (fe_crd[6]),
        .y2      (fe_crd[7]),
        .z2      (fe_crd[8]),
        .out_tag (fr_tag),
        .rad     (fr_rad),
        .mag     (fr_mag),
        .neg     (fr_neg)
    );

    p1tsm_sqrt #(
        .SW   (SW),
        .DW   (DW),
        .PAYW (PAYW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (fr_tag),
        .rad     (fr_rad),
        .in_pay  ({fr_neg, fr_mag}),
        .out_tag (sq_tag),
        .root    (sq_root),
        .out_pay (sq_pay)
    );

    assign sq_mag = sq_pay[ENTRIES*NMW-1:0];
    assign sq_neg = sq_pay[PAYW-1:ENTRIES*NMW];

    for (genvar e = 0; e < ENTRIES; e++)
    begin : g_lane
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;

        // Adding D before dividing by 2D rounds half away from zero.
        assign num = (NUMW'(sq_mag[e]) << FRAC_BITS) + NUMW'(sq_root);
        assign den = DENW'(sq_root) << 1;

        p1tsm_div #(
            .NUMW (NUMW),
            .DENW (DENW)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_tag  (sq_tag),
            .num     (num),
            .den     (den),
            .neg     (sq_neg[e]),
            .out_tag (dv_tag[e]),
            .entry   (dv_entry[e])
        );

        assign dv_valid[e] = dv_tag[e].valid;
    end

    assign out_valid  = &dv_valid;
    assign degenerate = dv_tag[0].degen;
    assign k00 = dv_entry[0];
    assign k11 = dv_entry[1];
    assign k22 = dv_entry[2];
    assign k01 = dv_entry[3];
    assign k02 = dv_entry[4];
    assign k12 = dv_entry[5];

    a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && en |=> !skid_valid_reg)
        else $error("skid register did not drain while the pipeline moved");

    a_skid_catches : assert property (@(posedge clk) disable iff (!rst_n)
        accept && !en |=> skid_valid_reg)
        else $error("beat taken during a freeze was not held in the skid register");

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (k00 == '0) && (k11 == '0) && (k22 == '0)
            && (k01 == '0) && (k02 == '0) && (k12 == '0))
        else $error("zero-area triangle produced a nonzero entry");

    a_lanes_agree : assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid == '0) || (dv_valid == '1))
        else $error("divider lanes lost step with each other");

endmodule

### dv/p1tsm_checker.sv
// Checker for the P1 triangle stiffness block: predicts each result from the accepted
// vertex beats with wide integer arithmetic and compares the returned beats in order.
// Depends on p1tsm_pkg for the output width and the clamp limits.
`timescale 1ns / 100ps
module p1tsm_checker
    import p1tsm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [31:0]         x0,
    input  logic signed [31:0]         y0,
    input  logic signed [31:0]         z0,
    input  logic signed [31:0]         x1,
    input  logic signed [31:0]         y1,
    input  logic signed [31:0]         z1,
    input  logic signed [31:0]         x2,
    input  logic signed [31:0]         y2,
    input  logic signed [31:0]         z2,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [OUT_BITS-1:0] k00,
    input  logic signed [OUT_BITS-1:0] k11,
    input  logic signed [OUT_BITS-1:0] k22,
    input  logic signed [OUT_BITS-1:0] k01,
    input  logic signed [OUT_BITS-1:0] k02,
    input  logic signed [OUT_BITS-1:0] k12,
    input  logic                       degenerate,
    output int                         errors,
    output int                         pending
);

    localparam int FRAC = 16;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] k[6];
        logic                       degen;
    } stiffness_t;

    stiffness_t expected_q[$];

    // Scales one numerator by 2^FRAC / (2D), rounding half away from zero, then clamps.
    function automatic logic signed [OUT_BITS-1:0] scale_entry(input wide_t num,
                                                               input wide_t d);
        wide_t mag;
        wide_t q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< FRAC) + d) / (d <<< 1);
        if (num < 0)
            return (q >= (wide_t'(1) <<< 31)) ? ENTRY_MIN : -q[OUT_BITS-1:0];
        return (q > wide_t'(32'h7FFF_FFFF)) ? ENTRY_MAX : q[OUT_BITS-1:0];
    endfunction

    function automatic stiffness_t triangle_stiffness(input logic signed [31:0] p[9]);
        stiffness_t r;
        wide_t e1[3];
        wide_t e2[3];
        wide_t cr[3];
        wide_t area2_sq;
        wide_t d;
        wide_t t;
        wide_t aa;
        wide_t bb;
        wide_t ab;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = wide_t'(p[3 + k]) - wide_t'(p[k]);
            e2[k] = wide_t'(p[6 + k]) - wide_t'(p[k]);
        end
        for (int k = 0; k < 3; k++)
            cr[k] = e1[(k + 1) % 3] * e2[(k + 2) % 3] - e1[(k + 2) % 3] * e2[(k + 1) % 3];
        area2_sq = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
        if (area2_sq == 0)
        begin
            for (int k = 0; k < 6; k++)
                r.k[k] = '0;
            r.degen = 1'b1;
            return r;
        end
        d = 0;
        for (int i = 71; i >= 0; i--)
        begin
            t = d | (wide_t'(1) <<< i);
            if (t * t <= area2_sq)
                d = t;
        end
        aa = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
        bb = e2[0] * e2[0] + e2[1] * e2[1] + e2[2] * e2[2];
        ab = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
        r.k[0] = scale_entry(aa + bb - ab - ab, d);
        r.k[1] = scale_entry(bb, d);
        r.k[2] = scale_entry(aa, d);
        r.k[3] = scale_entry(ab - bb, d);
        r.k[4] = scale_entry(ab - aa, d);
        r.k[5] = scale_entry(-ab, d);
        r.degen = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] coords[9];
        logic signed [OUT_BITS-1:0] got[6];
        stiffness_t exp_r;
        int bad;
        if (!rst_n)
        begin
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (in_valid && !in_stall)
            begin
                coords = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
                expected_q.push_back(triangle_stiffness(coords));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    bad++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    got = '{k00, k11, k22, k01, k02, k12};
                    for (int k = 0; k < 6; k++)
                        if (got[k] !== exp_r.k[k])
                        begin
                            $display("%0t: entry %0d expected %0d actual %0d",
                                     $time, k, exp_r.k[k], got[k]);
                            bad++;
                        end
                    if (degenerate !== exp_r.degen)
                    begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, exp_r.degen, degenerate);
                        bad++;
                    end
                end
            end
            errors  <= errors + bad;
            pending <= expected_q.size();
        end
    end

endmodule

### dv/tb_p1_triangle_stiffness_matrix.sv
// Testbench top for the P1 triangle stiffness block: drives directed and random
// triangles in bursts, stalls the result side, and reports the checker's verdict.
// Depends on p1tsm_pkg, p1tsm_checker and the block itself.
`timescale 1ns / 100ps
module tb_p1_triangle_stiffness_matrix;
    import p1tsm_pkg::*;

    localparam int RANDOM_TRIANGLES = 1400;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_BITS-1:0] k00, k11, k22, k01, k02, k12;
    logic degenerate;
    int errors;
    int pending;
    int accepted;
    int cycles;

    p1_triangle_stiffness_matrix uut (.*);

    p1tsm_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: random stall pattern, one long hold-off early on so the pipe backs up.
    initial
    begin
        bit held;
        int mode;
        held = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && accepted >= 200)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                mode = (cycles / 500) % 3;
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Presents one triangle and holds it until a beat is taken.
    task automatic send_triangle(input logic signed [31:0] p[9]);
        {x0, y0, z0, x1, y1, z1, x2, y2, z2} <= {p[0], p[1], p[2], p[3], p[4], p[5],
                                                 p[6], p[7], p[8]};
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        accepted++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_coord(input int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return $signed($urandom_range(0, 1 << 9)) - (1 << 8);
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] tri_c[9];
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        int style;
        int kind;
        int s;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        accepted = 0;
        in_valid = 1'b0;
        {x0, y0, z0, x1, y1, z1, x2, y2, z2} = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coincident, collinear, unit, extremes, tiny and huge areas.
        send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_triangle('{5, 5, 5, 5, 5, 5, 5, 5, 5});
        send_triangle('{0, 0, 0, 65536, 0, 0, 131072, 0, 0});
        send_triangle('{0, 0, 0, 65536, 65536, 65536, -65536, -65536, -65536});
        send_triangle('{0, 0, 0, 65536, 0, 0, 0, 65536, 0});
        send_triangle('{0, 0, 0, 0, 65536, 0, 0, 0, 65536});
        send_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        send_triangle('{0, 0, 0, 1000000, 0, 0, 0, 1, 0});
        send_triangle('{mn, mn, mn, mx, mn, mn, mn, mx, mn});
        send_triangle('{mx, mx, mx, mn, mx, mx, mx, mn, mx});
        send_triangle('{mn, mn, mn, mx, mx, mx, mn, mx, mn});
        send_triangle('{mx, mn, mx, mn, mx, mn, mx, mx, mn});
        send_triangle('{mn, mn, mn, mn, mn, mn, mx, mx, mx});
        send_triangle('{mn, 0, 0, mx, 0, 0, 0, 1, 0});
        send_triangle('{0, 0, 0, 65536, 0, 0, 32768, 1, 0});
        send_triangle('{0, 0, -1, -1, -1, -1, -1, 0, -1});
        send_triangle('{0, 0, 0, 0, 0, 0, 65536, 65536, 0});
        in_valid <= 1'b0;
        @(posedge clk);

        for (int n = 0; n < RANDOM_TRIANGLES; n++)
        begin
            kind = $urandom_range(0, 19);
            style = $urandom_range(0, 9);
            style = (style < 4) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
            for (int k = 0; k < 9; k++)
                tri_c[k] = pick_coord(style);
            if (kind == 0)
            begin
                // Collinear: third vertex on the line through the first two.
                s = $signed($urandom_range(0, 6)) - 3;
                for (int k = 0; k < 3; k++)
                begin
                    tri_c[k] = pick_coord(2);
                    tri_c[3 + k] = pick_coord(2);
                    tri_c[6 + k] = tri_c[k] + s * (tri_c[3 + k] - tri_c[k]);
                end
            end
            else if (kind == 1)
            begin
                for (int k = 0; k < 3; k++)
                    tri_c[3 + $urandom_range(0, 1) * 3 + k] = tri_c[k];
            end
            send_triangle(tri_c);
            idle_gap();
        end
        in_valid <= 1'b0;
        // Let the checker count the last accepted beat before polling it.
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
